FILE: sv/lddr_pkg.sv
package lddr_pkg;

    // Store geometry and field widths
    localparam int MAX_SLICES  = 4096;
    localparam int ADDR_W      = $clog2(MAX_SLICES);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int SAMPLE_BITS = 24;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int Q_W         = 17;
    localparam int OUT_W       = 4 * Q_W;
    localparam int TDATA_O_W   = ((OUT_W + 7) / 8) * 8;

    // Accumulators and the shared divider
    localparam int SUM1_W = Q_W + CNT_W - 1;
    localparam int DIV_W  = 2 * (Q_W - 1) + 1 + CNT_W - 1;
    localparam int STEP_W = $clog2(DIV_W + 1);
    localparam int SQ_W   = 2 * Q_W;
    localparam int SQ_CNT_W = 5;

    localparam logic [Q_W-1:0]      ONE_Q16   = Q_W'(65536);
    localparam logic [STEP_W-1:0]   XDIV_STEPS = STEP_W'(Q_W);
    localparam logic [STEP_W-1:0]   NDIV_STEPS = STEP_W'(DIV_W);
    localparam logic [SQ_CNT_W-1:0] SQ_LAST    = SQ_CNT_W'(Q_W - 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 1'b1;

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SETUP,
        OP_MAX_RD,
        OP_MAX_CMP,
        OP_IDX_CLR,
        OP_RD,
        OP_XDIV,
        OP_XZERO,
        OP_XTAKE,
        OP_ACC1,
        OP_ACC2,
        OP_MEAN_DIV,
        OP_MEAN_TAKE,
        OP_MS_DIV,
        OP_SQ_START,
        OP_SQ_STEP,
        OP_VM_DIV,
        OP_VM_TAKE,
        OP_VR_DIV,
        OP_VR_TAKE,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sq_last;
        logic idx_end;
        logic max_zero;
        logic cut;
        logic out_full;
    } t_status;

endpackage

FILE: sv/lddr_ram.sv
module lddr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/lddr_div.sv
module lddr_div
    import lddr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [DIV_W-1:0]       i_num,
    input  logic [SAMPLE_BITS-1:0] i_rem,
    input  logic [SAMPLE_BITS-1:0] i_den,
    input  logic [STEP_W-1:0]      i_steps,
    output logic [DIV_W-1:0]       o_quo,
    output logic                   o_done
);

    logic [SAMPLE_BITS-1:0] r_rem;
    logic [DIV_W-1:0]       r_num;
    logic [DIV_W-1:0]       r_quo;
    logic [SAMPLE_BITS-1:0] r_den;
    logic [STEP_W-1:0]      r_cnt;
    logic                   r_busy;
    logic                   r_done;

    logic [SAMPLE_BITS:0] trial;
    logic [SAMPLE_BITS:0] diff;
    logic                 ge;

    // One restoring step: bring down the next dividend bit and try the divisor.
    assign trial = {r_rem, r_num[DIV_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder, dividend and quotient shift registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_num <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
            r_num <= {r_num[DIV_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

FILE: sv/lddr_dp.sv
module lddr_dp
    import lddr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  logic [SAMPLE_BITS-1:0] i_slice_sum,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OUT_W-1:0]       o_out_data
);

    logic [CFG_W-1:0]       r_skip;
    logic [CFG_W-1:0]       r_thresh;
    logic [CNT_W-1:0]       r_count;
    logic [SAMPLE_BITS-1:0] r_max;
    logic [CNT_W-1:0]       r_n;
    logic [CNT_W-1:0]       r_c;
    logic [SAMPLE_BITS-1:0] r_m;
    logic [CNT_W-1:0]       r_idx;
    logic [Q_W-1:0]         r_x;
    logic [SUM1_W-1:0]      r_sum1;
    logic [DIV_W-1:0]       r_sum2;
    logic [DIV_W-1:0]       r_vm;
    logic [DIV_W-1:0]       r_vr;
    logic [Q_W-1:0]         r_mean;
    logic [Q_W-1:0]         r_vmq;
    logic [Q_W-1:0]         r_vrq;
    logic [SQ_W-1:0]        r_sqv;
    logic [SQ_W-1:0]        r_sqres;
    logic [SQ_W-1:0]        r_sqbit;
    logic [SQ_CNT_W-1:0]    r_sqcnt;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out;

    logic [SAMPLE_BITS-1:0] rdata;
    logic                   ram_we;
    logic                   ram_re;
    logic [CNT_W-1:0]       n_c;
    logic                   div_start;
    logic [DIV_W-1:0]       div_num;
    logic [SAMPLE_BITS-1:0] div_rem;
    logic [SAMPLE_BITS-1:0] div_den;
    logic [STEP_W-1:0]      div_steps;
    logic [DIV_W-1:0]       quo;
    logic                   div_done;
    logic [SQ_W-1:0]        x_sq;
    logic [Q_W-1:0]         rms;
    logic [Q_W-1:0]         dev_m;
    logic [Q_W-1:0]         dev_r;
    logic [SQ_W-1:0]        dev_m_sq;
    logic [SQ_W-1:0]        dev_r_sq;
    logic [SQ_W-1:0]        sq_trial;
    logic [DIV_W-17:0]      quo_hi;
    logic [Q_W-1:0]         quo_sat;
    logic [Q_W-1:0]         quo_hi_sat;

    assign ram_we = (i_cmd.op == OP_LOAD) && (r_count < CNT_W'(MAX_SLICES));
    assign ram_re = (i_cmd.op == OP_MAX_RD) || (i_cmd.op == OP_RD);

    lddr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_SLICES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_slice_sum),
        .i_re    (ram_re),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (rdata)
    );

    // Operand selection for the shared divider.
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_rem   = '0;
        div_den   = SAMPLE_BITS'(r_n);
        div_steps = NDIV_STEPS;
        unique case (i_cmd.op)
            OP_XDIV: begin
                div_start = 1'b1;
                div_num   = {rdata[0], {(DIV_W-1){1'b0}}};
                div_rem   = {1'b0, rdata[SAMPLE_BITS-1:1]};
                div_den   = r_m;
                div_steps = XDIV_STEPS;
            end
            OP_MEAN_DIV: begin
                div_start = 1'b1;
                div_num   = DIV_W'(r_sum1);
            end
            OP_MS_DIV: begin
                div_start = 1'b1;
                div_num   = r_sum2;
            end
            OP_VM_DIV: begin
                div_start = 1'b1;
                div_num   = r_vm;
            end
            OP_VR_DIV: begin
                div_start = 1'b1;
                div_num   = r_vr;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    lddr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_rem   (div_rem),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_quo   (quo),
        .o_done  (div_done)
    );

    // Counted slices: a long vector loses its trailing slices.
    always_comb begin
        if (r_count > r_thresh) begin
            n_c = (r_count > r_skip) ? (r_count - r_skip) : '0;
        end else begin
            n_c = r_count;
        end
    end

    // Squares and deviations for the accumulation steps.
    assign x_sq     = r_x * r_x;
    assign rms      = (r_sqres > SQ_W'(ONE_Q16)) ? ONE_Q16 : r_sqres[Q_W-1:0];
    assign dev_m    = (r_x >= r_mean) ? (r_x - r_mean) : (r_mean - r_x);
    assign dev_r    = (r_x >= rms) ? (r_x - rms) : (rms - r_x);
    assign dev_m_sq = dev_m * dev_m;
    assign dev_r_sq = dev_r * dev_r;
    assign sq_trial = r_sqres + r_sqbit;

    // Saturated quotients.
    assign quo_hi     = quo[DIV_W-1:16];
    assign quo_sat    = (quo > DIV_W'(ONE_Q16)) ? ONE_Q16 : quo[Q_W-1:0];
    assign quo_hi_sat = (quo_hi > (DIV_W-16)'(ONE_Q16)) ? ONE_Q16 : quo_hi[Q_W-1:0];

    // Configuration registers, loader state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip      <= '0;
            r_thresh    <= CFG_W'(4096);
            r_count     <= '0;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SKIP:   r_skip   <= i_cfg_data;
                    CFG_THRESH: r_thresh <= i_cfg_data;
                    default:    r_skip   <= r_skip;
                endcase
            end
            if (ram_we) begin
                r_count <= r_count + 1'b1;
                if (i_slice_sum > r_max) begin
                    r_max <= i_slice_sum;
                end
            end
            if (i_cmd.op == OP_SETUP) begin
                r_count <= '0;
                r_max   <= '0;
            end
            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Compute datapath.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_SETUP: begin
                r_n    <= r_count;
                r_c    <= n_c;
                r_m    <= (n_c != r_count) ? '0 : r_max;
                r_idx  <= '0;
                r_sum1 <= '0;
                r_sum2 <= '0;
                r_vm   <= '0;
                r_vr   <= '0;
            end
            OP_MAX_CMP: begin
                if (rdata > r_m) begin
                    r_m <= rdata;
                end
                r_idx <= r_idx + 1'b1;
            end
            OP_IDX_CLR: r_idx <= '0;
            OP_XZERO:   r_x <= '0;
            OP_XTAKE:   r_x <= quo[Q_W-1:0];
            OP_ACC1: begin
                r_sum1 <= r_sum1 + SUM1_W'(r_x);
                r_sum2 <= r_sum2 + DIV_W'(x_sq);
                r_idx  <= r_idx + 1'b1;
            end
            OP_ACC2: begin
                r_vm  <= r_vm + DIV_W'(dev_m_sq);
                r_vr  <= r_vr + DIV_W'(dev_r_sq);
                r_idx <= r_idx + 1'b1;
            end
            OP_MEAN_TAKE: r_mean <= quo_sat;
            OP_SQ_START: begin
                r_sqv   <= quo[SQ_W-1:0];
                r_sqres <= '0;
                r_sqbit <= SQ_W'(1) << (2 * (Q_W - 1));
                r_sqcnt <= '0;
                r_idx   <= '0;
            end
            OP_SQ_STEP: begin
                if (r_sqv >= sq_trial) begin
                    r_sqv   <= r_sqv - sq_trial;
                    r_sqres <= (r_sqres >> 1) + r_sqbit;
                end else begin
                    r_sqres <= r_sqres >> 1;
                end
                r_sqbit <= r_sqbit >> 2;
                r_sqcnt <= r_sqcnt + 1'b1;
            end
            OP_VM_TAKE: r_vmq <= quo_hi_sat;
            OP_VR_TAKE: r_vrq <= quo_hi_sat;
            OP_OUT:     r_out <= {r_vrq, r_vmq, ONE_Q16 - rms, ONE_Q16 - r_mean};
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    assign o_status.div_done = div_done;
    assign o_status.sq_last  = (r_sqcnt == SQ_LAST);
    assign o_status.idx_end  = (r_idx == r_c);
    assign o_status.max_zero = (r_m == '0);
    assign o_status.cut      = (r_c != r_n);
    assign o_status.out_full = r_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: sv/lddr_ctrl.sv
module lddr_ctrl
    import lddr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_last,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [21:0] {
        S_LOAD    = 22'd1 << 0,
        S_SETUP   = 22'd1 << 1,
        S_M_RD    = 22'd1 << 2,
        S_M_CMP   = 22'd1 << 3,
        S_P1_RD   = 22'd1 << 4,
        S_P1_GO   = 22'd1 << 5,
        S_P1_WT   = 22'd1 << 6,
        S_P1_ACC  = 22'd1 << 7,
        S_MEAN_GO = 22'd1 << 8,
        S_MEAN_WT = 22'd1 << 9,
        S_MS_GO   = 22'd1 << 10,
        S_MS_WT   = 22'd1 << 11,
        S_SQ      = 22'd1 << 12,
        S_P2_RD   = 22'd1 << 13,
        S_P2_GO   = 22'd1 << 14,
        S_P2_WT   = 22'd1 << 15,
        S_P2_ACC  = 22'd1 << 16,
        S_VM_GO   = 22'd1 << 17,
        S_VM_WT   = 22'd1 << 18,
        S_VR_GO   = 22'd1 << 19,
        S_VR_WT   = 22'd1 << 20,
        S_EMIT    = 22'd1 << 21
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencing: load, optional max pass, first pass, mean and rms,
    // second pass, variances, then hand the word to the output register.
    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        o_ready  = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    if (i_last) begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                o_cmd.op = OP_SETUP;
                n_state  = S_M_RD;
            end
            S_M_RD: begin
                if (!i_status.cut) begin
                    n_state = S_P1_RD;
                end else if (i_status.idx_end) begin
                    o_cmd.op = OP_IDX_CLR;
                    n_state  = S_P1_RD;
                end else begin
                    o_cmd.op = OP_MAX_RD;
                    n_state  = S_M_CMP;
                end
            end
            S_M_CMP: begin
                o_cmd.op = OP_MAX_CMP;
                n_state  = S_M_RD;
            end
            S_P1_RD: begin
                if (i_status.idx_end) begin
                    n_state = S_MEAN_GO;
                end else begin
                    o_cmd.op = OP_RD;
                    n_state  = S_P1_GO;
                end
            end
            S_P1_GO: begin
                if (i_status.max_zero) begin
                    o_cmd.op = OP_XZERO;
                    n_state  = S_P1_ACC;
                end else begin
                    o_cmd.op = OP_XDIV;
                    n_state  = S_P1_WT;
                end
            end
            S_P1_WT: begin
                if (i_status.div_done) begin
                    o_cmd.op = OP_XTAKE;
                    n_state  = S_P1_ACC;
                end
            end
            S_P1_ACC: begin
                o_cmd.op = OP_ACC1;
                n_state  = S_P1_RD;
            end
            S_MEAN_GO: begin
                o_cmd.op = OP_MEAN_DIV;
                n_state  = S_MEAN_WT;
            end
            S_MEAN_WT: begin
                if (i_status.div_done) begin
                    o_cmd.op = OP_MEAN_TAKE;
                    n_state  = S_MS_GO;
                end
            end
            S_MS_GO: begin
                o_cmd.op = OP_MS_DIV;
                n_state  = S_MS_WT;
            end
            S_MS_WT: begin
                if (i_status.div_done) begin
                    o_cmd.op = OP_SQ_START;
                    n_state  = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.op = OP_SQ_STEP;
                if (i_status.sq_last) begin
                    n_state = S_P2_RD;
                end
            end
            S_P2_RD: begin
                if (i_status.idx_end) begin
                    n_state = S_VM_GO;
                end else begin
                    o_cmd.op = OP_RD;
                    n_state  = S_P2_GO;
                end
            end
            S_P2_GO: begin
                if (i_status.max_zero) begin
                    o_cmd.op = OP_XZERO;
                    n_state  = S_P2_ACC;
                end else begin
                    o_cmd.op = OP_XDIV;
                    n_state  = S_P2_WT;
                end
            end
            S_P2_WT: begin
                if (i_status.div_done) begin
                    o_cmd.op = OP_XTAKE;
                    n_state  = S_P2_ACC;
                end
            end
            S_P2_ACC: begin
                o_cmd.op = OP_ACC2;
                n_state  = S_P2_RD;
            end
            S_VM_GO: begin
                o_cmd.op = OP_VM_DIV;
                n_state  = S_VM_WT;
            end
            S_VM_WT: begin
                if (i_status.div_done) begin
                    o_cmd.op = OP_VM_TAKE;
                    n_state  = S_VR_GO;
                end
            end
            S_VR_GO: begin
                o_cmd.op = OP_VR_DIV;
                n_state  = S_VR_WT;
            end
            S_VR_WT: begin
                if (i_status.div_done) begin
                    o_cmd.op = OP_VR_TAKE;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_status.out_full) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

FILE: sv/loudness_dynamic_range_stats.sv
// Loudness dynamic-range statistics.
// Input stream: one word per time slice, tdata carries the unsigned slice sum
// and tlast marks the final slice of a vector. Slices load one per cycle into
// a 4096-entry store; slices beyond that are dropped, but tlast still ends the
// vector. After the last slice, tready drops while the block computes.
// Compute work, with c counted slices: a maximum search over the c slices when
// trailing slices are cut, then two passes over them (one 17-step division per
// slice in the shared bit-serial divider), plus the four 45-step divisions and
// the 17-step square root. An all-zero maximum skips the per-slice divisions.
// Output stream: one word per vector, tdata holds 1-mean, 1-rms, variance about
// the mean and variance about the rms, Q1.16. The result sits in an output
// register; the next vector loads while it waits. A stalled receiver holds the
// block only once the next result is ready. Configuration writes (skip_slices,
// long_threshold_slices) take effect at once and belong in idle time.
// Reset empties the store and sets the threshold to 4096 slices.
module loudness_dynamic_range_stats
    import lddr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slice_sum[23:0]
    input  logic [SAMPLE_BITS-1:0] i_s_axis_tdata,
    input  logic                   i_s_axis_tlast,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // mean_complement[16:0], rms_complement[33:17], mean_variance[50:34],
    // rms_variance[67:51], zero fill
    output logic [TDATA_O_W-1:0]   o_m_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    t_cmd             cmd;
    t_status          status;
    logic [OUT_W-1:0] out_data;

    lddr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_last   (i_s_axis_tlast),
        .o_ready  (o_s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    lddr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_slice_sum (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (out_data)
    );

    assign o_m_axis_tdata = {{(TDATA_O_W-OUT_W){1'b0}}, out_data};

    // The controller never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_OUT) |-> !status.out_full)
        else $error("result written while output register full");

    // The divider signals completion for a single cycle.
    a_div_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.div_done |=> !status.div_done)
        else $error("divider done held for more than one cycle");

    // The mean complement and the mean variance stay within one in Q1.16.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (out_data[Q_W-1:0] <= ONE_Q16) &&
                            (out_data[3*Q_W-1:2*Q_W] <= ONE_Q16))
        else $error("result field above one");

endmodule

FILE: tb/lddr_stats_checker.sv
module lddr_stats_checker
    import lddr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slice_sum[23:0]
    input  logic [SAMPLE_BITS-1:0] i_s_axis_tdata,
    input  logic                   i_s_axis_tlast,
    input  logic                   i_s_axis_tvalid,
    input  logic                   i_s_axis_tready,
    // mean_complement[16:0], rms_complement[33:17], mean_variance[50:34],
    // rms_variance[67:51], zero fill
    input  logic [TDATA_O_W-1:0]   i_m_axis_tdata,
    input  logic                   i_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data,
    output int                     o_errors,
    output int                     o_pending,
    output int                     o_results
);

    typedef struct packed {
        logic [Q_W-1:0] mean_c;
        logic [Q_W-1:0] rms_c;
        logic [Q_W-1:0] mean_var;
        logic [Q_W-1:0] rms_var;
    } t_stats;

    // Shadow copy of the block's state and configuration.
    logic [SAMPLE_BITS-1:0] shadow_store [MAX_SLICES];
    int unsigned            shadow_count;
    logic [SAMPLE_BITS-1:0] shadow_max;
    logic [CFG_W-1:0]       skip_cfg;
    logic [CFG_W-1:0]       thresh_cfg;
    t_stats                 stats_q [$];

    assign o_pending = stats_q.size();

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 20; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic longint unsigned norm_x(input logic [SAMPLE_BITS-1:0] s,
                                               input logic [SAMPLE_BITS-1:0] m);
        if (m == 0) return 0;
        return (longint'(s) << 16) / m;
    endfunction

    // Statistics of the vector held in the shadow store.
    function automatic t_stats vector_stats();
        t_stats          r;
        int unsigned     n;
        int unsigned     c;
        logic [SAMPLE_BITS-1:0] m;
        longint unsigned x, d, s1, s2, vm, vr, mean, rms;
        n = shadow_count;
        c = n;
        s1 = 0; s2 = 0; vm = 0; vr = 0;
        if (n > thresh_cfg) c = (n > skip_cfg) ? n - skip_cfg : 0;
        if (c == n) begin
            m = shadow_max;
        end else begin
            m = 0;
            for (int i = 0; i < c; i++)
                if (shadow_store[i] > m) m = shadow_store[i];
        end
        for (int i = 0; i < c; i++) begin
            x = norm_x(shadow_store[i], m);
            s1 += x;
            s2 += x * x;
        end
        mean = (n != 0) ? s1 / n : 0;
        rms = int_sqrt((n != 0) ? s2 / n : 0);
        if (mean > 65536) mean = 65536;
        if (rms > 65536) rms = 65536;
        for (int i = 0; i < c; i++) begin
            x = norm_x(shadow_store[i], m);
            d = (x >= mean) ? x - mean : mean - x;
            vm += d * d;
            d = (x >= rms) ? x - rms : rms - x;
            vr += d * d;
        end
        vm = (n != 0) ? (vm / n) >> 16 : 0;
        vr = (n != 0) ? (vr / n) >> 16 : 0;
        if (vm > 65536) vm = 65536;
        if (vr > 65536) vr = 65536;
        r.mean_c   = Q_W'(65536 - mean);
        r.rms_c    = Q_W'(65536 - rms);
        r.mean_var = Q_W'(vm);
        r.rms_var  = Q_W'(vr);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [Q_W-1:0] exp_v,
                               input logic [Q_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_stats exp_s;
        if (!i_rst_n) begin
            shadow_count = 0;
            shadow_max   = 0;
            skip_cfg     = 0;
            thresh_cfg   = 13'd4096;
            o_errors     = 0;
            o_results    = 0;
            stats_q.delete();
        end else begin
            // Register writes.
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SKIP) skip_cfg = i_cfg_data;
                else if (i_cfg_idx == CFG_THRESH) thresh_cfg = i_cfg_data;
            end
            // Slice loads; a slice past the store's end is dropped.
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                if (shadow_count < MAX_SLICES) begin
                    shadow_store[shadow_count] = i_s_axis_tdata;
                    shadow_count++;
                    if (i_s_axis_tdata > shadow_max) shadow_max = i_s_axis_tdata;
                end
                if (i_s_axis_tlast) begin
                    stats_q.push_back(vector_stats());
                    shadow_count = 0;
                    shadow_max   = 0;
                end
            end
            // Result words against the oldest expectation.
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (stats_q.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, i_m_axis_tdata);
                    o_errors++;
                end else begin
                    exp_s = stats_q.pop_front();
                    check_field("mean_complement", exp_s.mean_c,
                                i_m_axis_tdata[Q_W-1:0]);
                    check_field("rms_complement", exp_s.rms_c,
                                i_m_axis_tdata[2*Q_W-1:Q_W]);
                    check_field("mean_variance", exp_s.mean_var,
                                i_m_axis_tdata[3*Q_W-1:2*Q_W]);
                    check_field("rms_variance", exp_s.rms_var,
                                i_m_axis_tdata[4*Q_W-1:3*Q_W]);
                    o_results++;
                end
            end
        end
    end

endmodule

FILE: tb/tb_top.sv
module tb_top;
    import lddr_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic [SAMPLE_BITS-1:0] s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_O_W-1:0]   m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx = CFG_SKIP;
    logic [CFG_W-1:0]       cfg_data = '0;

    int errors, pending, results;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_req = 0;
    int unsigned cycles = 0;
    int unsigned slices_sent = 0;
    logic [SAMPLE_BITS-1:0] vec_q [$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    loudness_dynamic_range_stats u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    lddr_stats_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_results       (results)
    );

    // Run limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here.
    always @(negedge i_clk) begin
        int unsigned hold_left;
        if (hold_req) begin
            hold_req = 0;
            hold_left = 3000;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one word; returns at the falling edge after it is taken.
    task automatic send_slice(input logic [SAMPLE_BITS-1:0] v, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tdata  <= v;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        slices_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_vector();
        for (int i = 0; i < vec_q.size(); i++)
            send_slice(vec_q[i], i == vec_q.size() - 1);
        vec_q.delete();
    endtask

    // Random vector contents: full range, small values, zeros or one spike.
    task automatic random_vector(input int unsigned len);
        int unsigned kind;
        kind = $urandom_range(7);
        for (int i = 0; i < len; i++) begin
            case (kind)
                0:       vec_q.push_back(SAMPLE_BITS'($urandom_range(15)));
                1:       vec_q.push_back('0);
                2:       vec_q.push_back((i == 0) ? 24'hFFFFFF
                                                  : SAMPLE_BITS'($urandom_range(3)));
                default: vec_q.push_back(SAMPLE_BITS'($urandom));
            endcase
        end
    endtask

    // Waits for every result, lets the block settle, then writes registers.
    task automatic set_config(input logic [CFG_W-1:0] skip_v,
                              input logic [CFG_W-1:0] thresh_v);
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SKIP;
        cfg_data <= skip_v;
        @(negedge i_clk);
        cfg_idx  <= CFG_THRESH;
        cfg_data <= thresh_v;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int unsigned len;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, defaults: extremes, single slice, all zeros.
        set_config(13'd0, 13'd4096);
        vec_q = '{24'h0};                         send_vector();
        vec_q = '{24'hFFFFFF};                    send_vector();
        vec_q = '{24'h0, 24'h0, 24'h0};           send_vector();
        vec_q = '{24'hFFFFFF, 24'h0, 24'h1, 24'h800000}; send_vector();
        vec_q = '{24'h1, 24'h2, 24'h3};           send_vector();

        // Long vectors lose their tail; the maximum sits in the cut part.
        set_config(13'd1, 13'd2);
        vec_q = '{24'd5, 24'd10, 24'hFFFFFF};     send_vector();
        vec_q = '{24'd7, 24'd9};                  send_vector();

        // Nothing counted: threshold zero, skip at the store size.
        set_config(13'd4096, 13'd0);
        vec_q = '{24'h123456, 24'hABCDEF};        send_vector();
        vec_q = '{24'hFFFFFF};                    send_vector();

        // Random part in three idling phases, with register changes.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 78 : 0;
            recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 21 : 0;
            for (int blk = 0; blk < 2; blk++) begin
                case ($urandom_range(3))
                    0: set_config(CFG_W'($urandom_range(6)), CFG_W'($urandom_range(12)));
                    1: set_config(13'd4096, CFG_W'($urandom_range(4)));
                    2: set_config(CFG_W'($urandom_range(3)), 13'd0);
                    default: set_config(CFG_W'($urandom_range(8)), 13'd4096);
                endcase
                if (blk == 1) begin
                    // Output held back while short vectors keep coming.
                    hold_req = 1;
                    repeat (8) begin
                        random_vector(2);
                        send_vector();
                    end
                end
                len = 0;
                while (len < 90) begin
                    vec_q.delete();
                    random_vector(($urandom_range(9) == 0) ? $urandom_range(40)
                                                         : $urandom_range(1, 8));
                    if (vec_q.size() == 0) vec_q.push_back(SAMPLE_BITS'($urandom));
                    len += vec_q.size();
                    send_vector();
                end
            end
        end

        // Drain and settle.
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);

        $display("Sent %0d slices and checked %0d statistics words across", slices_sent,
                 results);
        $display("cut, uncut, empty and zero vectors under three idling patterns.");
        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
